// File: src/bdh_pkg.sv
package bdh_pkg;

  // Fixed by the button wiring.
  localparam int BUTTON_COUNT = 3;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] STABLE_COUNT_RST = 4'd4;
  localparam logic [15:0] HOLD_TICKS_RST = 16'd800;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 1'b1;

  localparam logic [1:0] BTN_PUSH = 2'd0;
  localparam logic [1:0] BTN_LEFT = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;

  typedef enum logic [2:0] {
    KIND_PUSH_EDGE  = 3'd0,
    KIND_PUSH_PRESS = 3'd1,
    KIND_LEFT       = 3'd2,
    KIND_RIGHT      = 3'd3,
    KIND_PUSH_HOLD  = 3'd4,
    KIND_LEFT_HOLD  = 3'd5,
    KIND_RIGHT_HOLD = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]  button_index;
    logic        raw_level;
    logic [31:0] now_ticks;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic       event_pressed;
    logic       last;
  } out_word_t;

  // Up to two events raised by one poll.
  typedef struct packed {
    logic       two;
    logic [2:0] kind0;
    logic       pressed0;
    logic [2:0] kind1;
    logic       pressed1;
  } evt_pair_t;

  typedef struct packed {
    logic      valid;
    evt_pair_t pair;
  } q_slot_t;

  function automatic kind_t press_kind(input logic [1:0] b);
    kind_t k;
    unique case (b)
      BTN_PUSH:  k = KIND_PUSH_PRESS;
      BTN_LEFT:  k = KIND_LEFT;
      BTN_RIGHT: k = KIND_RIGHT;
      default:   k = KIND_PUSH_PRESS;
    endcase
    return k;
  endfunction

  function automatic kind_t hold_kind(input logic [1:0] b);
    kind_t k;
    unique case (b)
      BTN_PUSH:  k = KIND_PUSH_HOLD;
      BTN_LEFT:  k = KIND_LEFT_HOLD;
      BTN_RIGHT: k = KIND_RIGHT_HOLD;
      default:   k = KIND_PUSH_HOLD;
    endcase
    return k;
  endfunction

endpackage

// File: src/button_debounce_hold_detector_core.sv
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  in_word_t: button_index, raw_level, now_ticks
// out_     output     out_valid/out_stall out_word_t: event_kind, event_pressed, last
// cfg_     input      cfg_we             cfg_index, cfg_wdata (0 stable_count, 1 hold_ticks)
//
// A poll is taken when in_valid is high and in_stall low; the per-button state
// is updated at that edge. Its events are written to the queue at that same
// edge and move from the queue head into the output register once that register
// is free (out_stall low). One word per cycle while out_stall is low, so a poll
// that raises two events holds the output register for two words. The sustained
// poll rate is set by the single output register draining the event queue.
// Reset (rst_n low, synchronous) restores register defaults and clears all
// button state, the queue and the output.
// in_stall rises only when the two-entry event queue is full.

module button_debounce_hold_detector_core #(
  parameter int TIME_WIDTH = bdh_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // poll input
  input  logic                           in_valid,
  input  bdh_pkg::in_word_t              in_word,
  output logic                           in_stall,
  // events out
  output logic                           out_valid,
  output bdh_pkg::out_word_t             out_word,
  input  logic                           out_stall,
  // register writes
  input  logic                           cfg_we,
  input  logic [bdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bdh_pkg::q_slot_t q_push;   // front -> queue
  bdh_pkg::q_slot_t q_head;   // queue -> back
  logic             q_full;
  logic             q_pop;

  // Front: debounce, hold timing, event classification.
  bdh_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // Queue of event pairs, one entry per poll that raised anything.
  bdh_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // Back: splits each pair into words and marks the last one.
  bdh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

endmodule

// File: src/bdh_front.sv
module bdh_front #(
  parameter int TIME_WIDTH = bdh_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  bdh_pkg::in_word_t              in_word,
  output logic                           in_stall,
  input  logic                           cfg_we,
  input  logic [bdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           q_full,
  output bdh_pkg::q_slot_t               q_push
);

  localparam int NB = bdh_pkg::BUTTON_COUNT;

  logic [3:0]  stable_count_r, stable_count_nxt;
  logic [15:0] hold_ticks_r, hold_ticks_nxt;

  logic                  stable_r[NB], stable_nxt[NB];
  logic                  cand_r[NB], cand_nxt[NB];
  logic [3:0]            agree_r[NB], agree_nxt[NB];
  logic [TIME_WIDTH-1:0] ptime_r[NB], ptime_nxt[NB];
  logic                  hdone_r[NB], hdone_nxt[NB];

  logic [1:0]            b;
  logic                  pressed;
  logic [3:0]            need;
  logic [3:0]            agree_new;
  logic                  flip;
  logic                  st_new, hd_new;
  logic [TIME_WIDTH-1:0] now_t, pt_new, elapsed;
  logic                  e_edge, e_rel, e_hold;

  assign in_stall = q_full;
  assign b        = in_word.button_index;
  assign pressed  = ~in_word.raw_level;
  assign need     = (stable_count_r == 4'd0) ? 4'd1 : stable_count_r;
  assign now_t    = TIME_WIDTH'(in_word.now_ticks);

  always_comb begin
    stable_count_nxt = stable_count_r;
    hold_ticks_nxt   = hold_ticks_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bdh_pkg::CFG_STABLE_COUNT: stable_count_nxt = cfg_wdata[3:0];
        bdh_pkg::CFG_HOLD_TICKS:   hold_ticks_nxt   = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stable_nxt = stable_r;
    cand_nxt   = cand_r;
    agree_nxt  = agree_r;
    ptime_nxt  = ptime_r;
    hdone_nxt  = hdone_r;
    q_push     = '0;
    agree_new  = '0;
    flip       = 1'b0;
    st_new     = 1'b0;
    hd_new     = 1'b0;
    pt_new     = '0;
    elapsed    = '0;
    e_edge     = 1'b0;
    e_rel      = 1'b0;
    e_hold     = 1'b0;
    if (in_valid && !in_stall && (b < 2'(NB))) begin
      if (pressed != cand_r[b]) begin
        // level changed: restart agreement, poll ends here
        cand_nxt[b]  = pressed;
        agree_nxt[b] = 4'd1;
      end else begin
        agree_new    = (agree_r[b] < need) ? agree_r[b] + 4'd1 : need;
        agree_nxt[b] = agree_new;
        flip   = (agree_new == need) && (stable_r[b] != cand_r[b]);
        st_new = flip ? cand_r[b] : stable_r[b];
        hd_new = (flip && st_new) ? 1'b0 : hdone_r[b];
        pt_new = (flip && st_new) ? now_t : ptime_r[b];
        e_edge = flip && (b == bdh_pkg::BTN_PUSH);
        e_rel  = flip && !st_new && !hdone_r[b];
        elapsed = now_t - pt_new;
        e_hold = st_new && !hd_new && (elapsed >= TIME_WIDTH'(hold_ticks_r));
        stable_nxt[b] = st_new;
        ptime_nxt[b]  = pt_new;
        hdone_nxt[b]  = hd_new | e_hold;

        // order: push edge, then press, then hold
        q_push.valid = e_edge | e_rel | e_hold;
        if (e_edge) begin
          q_push.pair.kind0    = bdh_pkg::KIND_PUSH_EDGE;
          q_push.pair.pressed0 = st_new;
          q_push.pair.two      = e_rel | e_hold;
          q_push.pair.kind1    = e_rel ? bdh_pkg::press_kind(b) : bdh_pkg::hold_kind(b);
          q_push.pair.pressed1 = 1'b1;
        end else if (e_rel) begin
          q_push.pair.kind0    = bdh_pkg::press_kind(b);
          q_push.pair.pressed0 = 1'b1;
        end else begin
          q_push.pair.kind0    = bdh_pkg::hold_kind(b);
          q_push.pair.pressed0 = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_count_r <= bdh_pkg::STABLE_COUNT_RST;
      hold_ticks_r   <= bdh_pkg::HOLD_TICKS_RST;
      for (int i = 0; i < NB; i++) begin
        stable_r[i] <= 1'b0;
        cand_r[i]   <= 1'b0;
        agree_r[i]  <= '0;
        ptime_r[i]  <= '0;
        hdone_r[i]  <= 1'b0;
      end
    end else begin
      stable_count_r <= stable_count_nxt;
      hold_ticks_r   <= hold_ticks_nxt;
      stable_r       <= stable_nxt;
      cand_r         <= cand_nxt;
      agree_r        <= agree_nxt;
      ptime_r        <= ptime_nxt;
      hdone_r        <= hdone_nxt;
    end
  end

endmodule

// File: src/bdh_fifo.sv
module bdh_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  bdh_pkg::q_slot_t q_push,
  output logic             q_full,
  output bdh_pkg::q_slot_t q_head,
  input  logic             q_pop
);

  localparam int DEPTH = bdh_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  bdh_pkg::evt_pair_t mem_r[DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_full      = (count_r == CW'(DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.pair  = mem_r[rd_ptr_r];
  assign do_push     = q_push.valid && !q_full;
  assign do_pop      = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: src/bdh_back.sv
module bdh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bdh_pkg::q_slot_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  output bdh_pkg::out_word_t out_word,
  input  logic               out_stall
);

  logic               out_valid_r, out_valid_nxt;
  bdh_pkg::out_word_t out_word_r, out_word_nxt;
  logic               sec_valid_r, sec_valid_nxt;
  logic [2:0]         sec_kind_r, sec_kind_nxt;
  logic               sec_pressed_r, sec_pressed_nxt;
  logic               load;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign load      = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_word_nxt    = out_word_r;
    sec_valid_nxt   = sec_valid_r;
    sec_kind_nxt    = sec_kind_r;
    sec_pressed_nxt = sec_pressed_r;
    q_pop           = 1'b0;
    if (load) begin
      if (sec_valid_r) begin
        out_valid_nxt              = 1'b1;
        out_word_nxt.event_kind    = sec_kind_r;
        out_word_nxt.event_pressed = sec_pressed_r;
        out_word_nxt.last          = 1'b1;
        sec_valid_nxt              = 1'b0;
      end else if (q_head.valid) begin
        out_valid_nxt              = 1'b1;
        out_word_nxt.event_kind    = q_head.pair.kind0;
        out_word_nxt.event_pressed = q_head.pair.pressed0;
        out_word_nxt.last          = !q_head.pair.two;
        sec_valid_nxt              = q_head.pair.two;
        sec_kind_nxt               = q_head.pair.kind1;
        sec_pressed_nxt            = q_head.pair.pressed1;
        q_pop                      = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r    <= out_word_nxt;
    sec_kind_r    <= sec_kind_nxt;
    sec_pressed_r <= sec_pressed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

endmodule

// File: src/bdh_chk.sv
module bdh_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input bdh_pkg::out_word_t out_word,
  input logic               out_stall
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");

  // second word of a pair follows at once
  a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_word.last |=> out_valid && out_word.last)
    else $error("pair tail missing");

  // only a push edge opens a pair
  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |-> out_word.event_kind == bdh_pkg::KIND_PUSH_EDGE)
    else $error("pair not headed by push edge");

  // release edge of a pair is followed by the push press
  a_rel_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_word.last && !out_word.event_pressed
    |=> out_word.event_kind == bdh_pkg::KIND_PUSH_PRESS)
    else $error("release edge not followed by press");

  // released flag only on push edges
  a_rel_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.event_pressed |-> out_word.event_kind == bdh_pkg::KIND_PUSH_EDGE)
    else $error("released flag on non-edge event");

endmodule

bind button_debounce_hold_detector_core bdh_chk u_chk (.*);

// File: verif/button_debounce_hold_detector_core_tb.sv
`timescale 1ns / 100ps

module button_debounce_hold_detector_core_tb;
  import bdh_pkg::*;

  // Poll index past the last button: the core must drop it silently.
  localparam logic [1:0] BTN_NONE = 2'd3;
  localparam int PHASES = 9;
  localparam int POLLS_PER_PHASE = 185;
  // Long receiver hold-off, in cycles, to back the event queue up into in_stall.
  localparam int HOLDOFF_CYCLES = 300;
  // Settle time after the last expected event before touching registers.
  localparam int SETTLE_CYCLES = 6;
  // Cycles with no word moving on either channel before the run is called hung.
  localparam int QUIET_LIMIT = 4000;

  // Tracks debounce/hold state per button and keeps the events still owed by the core.
  class press_event_board;
    logic [3:0]  stable_count;
    logic [15:0] hold_ticks;
    bit          stable_dn [BUTTON_COUNT];
    bit          cand_dn   [BUTTON_COUNT];
    bit          hold_done [BUTTON_COUNT];
    logic [3:0]  agree     [BUTTON_COUNT];
    logic [31:0] press_at  [BUTTON_COUNT];
    out_word_t   events_due[$];
    int          errors;

    function new();
      stable_count = STABLE_COUNT_RST;
      hold_ticks   = HOLD_TICKS_RST;
      errors       = 0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        stable_dn[i] = 1'b0;
        cand_dn[i]   = 1'b0;
        hold_done[i] = 1'b0;
        agree[i]     = '0;
        press_at[i]  = '0;
      end
    endfunction

    // Work out the events one accepted poll raises and queue them in order.
    function void note_poll(in_word_t w);
      logic [1:0] b;
      logic [3:0] need;
      bit         dn;
      kind_t      k;
      out_word_t  evs[$];
      out_word_t  e;
      b    = w.button_index;
      dn   = !w.raw_level;
      need = (stable_count == 4'd0) ? 4'd1 : stable_count;
      if (b == BTN_NONE) return;
      // a new level only restarts the count; nothing else this poll
      if (dn != cand_dn[b]) begin
        cand_dn[b] = dn;
        agree[b]   = 4'd1;
        return;
      end
      if (agree[b] < need) agree[b] = agree[b] + 4'd1;
      else agree[b] = need;
      if (agree[b] == need && stable_dn[b] != cand_dn[b]) begin
        stable_dn[b] = cand_dn[b];
        e.last = 1'b0;
        if (stable_dn[b]) begin
          press_at[b]  = w.now_ticks;
          hold_done[b] = 1'b0;
          if (b == BTN_PUSH) begin
            e.event_kind = KIND_PUSH_EDGE; e.event_pressed = 1'b1; evs.push_back(e);
          end
        end else if (b == BTN_PUSH) begin
          e.event_kind = KIND_PUSH_EDGE; e.event_pressed = 1'b0; evs.push_back(e);
          if (!hold_done[b]) begin
            e.event_kind = KIND_PUSH_PRESS; e.event_pressed = 1'b1; evs.push_back(e);
          end
        end else if (!hold_done[b]) begin
          if (b == BTN_LEFT) k = KIND_LEFT;
          else k = KIND_RIGHT;
          e.event_kind = k; e.event_pressed = 1'b1; evs.push_back(e);
        end
      end
      // elapsed time wraps at 32 bits
      if (stable_dn[b] && !hold_done[b] && (w.now_ticks - press_at[b]) >= hold_ticks) begin
        hold_done[b] = 1'b1;
        case (b)
          BTN_PUSH: k = KIND_PUSH_HOLD;
          BTN_LEFT: k = KIND_LEFT_HOLD;
          default:  k = KIND_RIGHT_HOLD;
        endcase
        e.event_kind = k; e.event_pressed = 1'b1; e.last = 1'b0; evs.push_back(e);
      end
      if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
      foreach (evs[i]) events_due.push_back(evs[i]);
    endfunction

    function void check_event(out_word_t got);
      out_word_t exp;
      if (events_due.size() == 0) begin
        $display("%0t: unexpected event, expected none, got kind %0d pressed %0d last %0d",
                 $time, got.event_kind, got.event_pressed, got.last);
        errors++;
        return;
      end
      exp = events_due.pop_front();
      if (got.event_kind !== exp.event_kind) begin
        $display("%0t: event_kind expected %0d, got %0d", $time, exp.event_kind, got.event_kind);
        errors++;
      end
      if (got.event_pressed !== exp.event_pressed) begin
        $display("%0t: event_pressed expected %0d, got %0d",
                 $time, exp.event_pressed, got.event_pressed);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last expected %0d, got %0d", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_word_t              in_word   = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  press_event_board board;

  // Idle rates in percent, changed per phase by the stimulus thread.
  int          send_idle_pct = 34;
  int          rcv_idle_pct  = 69;
  // Hold-off request: stimulus bumps the ask count, receiver notices the change.
  int          holdoff_ask   = 0;
  int          holdoff_seen  = 0;
  int          holdoff_left  = 0;
  int          polls_sent    = 0;
  int          cur_sc        = STABLE_COUNT_RST;
  int          cur_ht        = HOLD_TICKS_RST;
  logic [31:0] tick_now      = '0;
  bit          noise_on      = 1'b0;

  // Per-phase register settings; both extremes of each register appear,
  // and stable_count/hold_ticks of zero hit the degenerate cases.
  logic [3:0]  phase_sc [PHASES] = '{4'd15, 4'd1, 4'd3, 4'd0, 4'd7, 4'd2, 4'd4, 4'd15, 4'd1};
  logic [15:0] phase_ht [PHASES] = '{16'd65535, 16'd1, 16'd40, 16'd0, 16'd300,
                                     16'd5, 16'd800, 16'd2000, 16'd65535};

  button_debounce_hold_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Result side: check every accepted word, then pick next cycle's stall.
  // Signals are read right after the edge, so they hold their pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_event(out_word);
    if (holdoff_ask != holdoff_seen) begin
      holdoff_seen = holdoff_ask;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Offer one poll word, with random idle cycles ahead of it, and wait for acceptance.
  // in_valid stays high on return so back-to-back words need no extra edge.
  task automatic send_poll(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_poll(w);
    if (w.button_index != BTN_NONE) polls_sent++;
  endtask

  // Advance the tick counter and poll one button; with noise on, a stray poll
  // of any index (the ignored one included) may slip in first.
  task automatic poll(input logic [1:0] b, input logic lvl, input logic [31:0] step);
    in_word_t w;
    if (noise_on && $urandom_range(0, 9) == 0) begin
      w.button_index = 2'($urandom_range(0, 3));
      w.raw_level    = 1'($urandom);
      w.now_ticks    = tick_now;
      send_poll(w);
    end
    tick_now       = tick_now + step;
    w.button_index = b;
    w.raw_level    = lvl;
    w.now_ticks    = tick_now;
    send_poll(w);
  endtask

  // Contact bounce: up to three polls at random levels.
  task automatic bounce(input logic [1:0] b);
    repeat ($urandom_range(0, 3)) poll(b, 1'($urandom), 32'($urandom_range(0, 3)));
  endtask

  // One full press: bounce, settle low, stay down for a random span that lands
  // either side of hold_ticks, bounce, settle high.
  task automatic press_cycle(input logic [1:0] b);
    int          need;
    int          hold_polls;
    logic [31:0] span;
    need       = (cur_sc == 0) ? 1 : cur_sc;
    hold_polls = $urandom_range(1, 5);
    span       = $urandom_range(0, 2 * cur_ht + 2);
    bounce(b);
    repeat (need + $urandom_range(0, 2)) poll(b, 1'b0, 32'($urandom_range(0, 3)));
    repeat (hold_polls) poll(b, 1'b0, span / hold_polls);
    bounce(b);
    repeat (need + $urandom_range(0, 2)) poll(b, 1'b1, 32'($urandom_range(0, 3)));
  endtask

  // Stop offering and wait until every owed event has come out, then let the
  // core settle (a poll with no events may still be in flight).
  task automatic drain();
    in_valid <= 1'b0;
    while (board.events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; cfg_we stays high between them.
  // Upper bits of the stable_count write are junk and must be ignored.
  task automatic set_thresholds(input logic [3:0] sc, input logic [15:0] ht);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STABLE_COUNT;
    cfg_wdata <= {12'($urandom), sc};
    @(posedge clk);
    cfg_index <= CFG_HOLD_TICKS;
    cfg_wdata <= ht;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.stable_count = sc;
    board.hold_ticks   = ht;
    cur_sc = sc;
    cur_ht = ht;
  endtask

  // Hang detector: counts edges with no word moving on either channel.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("button_debounce_hold_detector_core regression: fail");
    $finish;
  end

  initial begin
    int  target;
    bit  paused;
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero stable count acts as one, zero hold fires with the down edge.
    set_thresholds(4'd0, 16'd0);
    tick_now = 32'hFFFF_FFF0;
    poll(BTN_PUSH, 1'b0, 0);
    poll(BTN_PUSH, 1'b0, 1);      // down edge then hold, same poll
    poll(BTN_PUSH, 1'b1, 1);
    poll(BTN_PUSH, 1'b1, 1);      // up edge only, hold already reported
    poll(BTN_NONE, 1'b0, 1);      // ignored index
    drain();

    set_thresholds(4'd2, 16'd16);
    poll(BTN_LEFT, 1'b0, 1);
    poll(BTN_LEFT, 1'b0, 1);
    poll(BTN_LEFT, 1'b1, 1);
    poll(BTN_LEFT, 1'b1, 1);      // short left press
    tick_now = 32'hFFFF_FFF8;
    poll(BTN_RIGHT, 1'b0, 0);
    poll(BTN_RIGHT, 1'b0, 0);
    poll(BTN_RIGHT, 1'b0, 32'h18); // tick wraps to 0x10: right hold
    poll(BTN_RIGHT, 1'b1, 1);
    poll(BTN_RIGHT, 1'b1, 1);     // no press after a hold
    poll(BTN_PUSH, 1'b0, 1);
    poll(BTN_PUSH, 1'b0, 1);      // down edge
    poll(BTN_PUSH, 1'b1, 1);
    poll(BTN_PUSH, 1'b1, 1);      // up edge plus push press
    poll(BTN_LEFT, 1'b0, 1);
    poll(BTN_LEFT, 1'b0, 1);
    poll(BTN_LEFT, 1'b0, 15);     // one tick short of the hold
    poll(BTN_LEFT, 1'b0, 1);      // exactly hold_ticks
    poll(BTN_LEFT, 1'b1, 1);
    poll(BTN_LEFT, 1'b0, 1);      // bounce back restarts the count
    poll(BTN_LEFT, 1'b1, 1);
    poll(BTN_LEFT, 1'b1, 1);

    // Random: press cycles with noise; sender/receiver idle mix changes by thirds.
    noise_on = 1'b1;
    paused   = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_thresholds(phase_sc[ph], phase_ht[ph]);
      case (ph / 3)
        0: begin send_idle_pct = 34; rcv_idle_pct = 69; end
        1: begin send_idle_pct = 69; rcv_idle_pct = 34; end
        default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      // odd phases start just short of the wrap so holds straddle it
      if (ph % 2 == 1) tick_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 4 * cur_ht));
      else tick_now = $urandom();
      // back the queue up into in_stall while polls keep coming
      if (ph == 2) holdoff_ask++;
      target = polls_sent + POLLS_PER_PHASE;
      while (polls_sent < target) begin
        if (ph == 4 && !paused && polls_sent > target - POLLS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
        press_cycle(2'($urandom_range(0, 2)));
      end
    end

    drain();
    if (board.errors == 0) begin
      $display("button_debounce_hold_detector_core regression: pass");
    end else begin
      $display("button_debounce_hold_detector_core regression: fail");
    end
    $finish;
  end

endmodule
